/* hdl/pol_pkg.sv */
`timescale 1ns / 1ps

package pol_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5,
        OP_READ      = 3'd6,
        OP_NONE      = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What the decoder asks the cell row to do with one word.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic do_read;
    } t_action;

endpackage

/* hdl/positional_ordered_list_core.sv */
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words held in a row of CAPACITY
// register cells. Each request word inserts or removes at the front, the
// back or a 1-based position, or reads at a position, and yields one result
// word with a status, the new count, the value read and the head and tail
// after the request. A request is registered on entry and completes once
// the output is free: all cells shift or hold in parallel, so one request
// is taken per clock while the output is not held, and the result word is
// registered in the output register. An output register lets a new request
// enter while a result waits.

module positional_ordered_list_core import pol_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [DATA_W-1:0]  i_value,
    input  logic [POS_W-1:0]          i_position,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [COUNT_W-1:0]        o_new_count,
    output logic signed [DATA_W-1:0]  o_read_value,
    output logic signed [DATA_W-1:0]  o_head_value,
    output logic signed [DATA_W-1:0]  o_tail_value
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);

    logic              r_req_valid;
    logic [OP_W-1:0]   r_opcode;
    logic [DATA_W-1:0] r_value;
    logic [POS_W-1:0]  r_position;
    logic [CW-1:0]     r_count;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [CW-1:0]     r_new_count;
    logic [DATA_W-1:0] r_read_value;
    logic [DATA_W-1:0] r_head_value;
    logic [DATA_W-1:0] r_tail_value;

    logic              w_exec;
    t_action           w_action;
    t_action           w_cell_action;
    logic [IW-1:0]     w_index;
    t_status           w_status;
    logic [CW-1:0]     w_next_count;
    logic [DATA_W-1:0] w_read_value;
    logic [DATA_W-1:0] w_head_value;
    logic [DATA_W-1:0] w_tail_value;

    assign w_exec     = r_req_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_req_valid || w_exec;

    pol_decode #(
        .CAPACITY     (CAPACITY)
    ) u_decode (
        .i_opcode     (r_opcode),
        .i_position   (r_position),
        .i_count      (r_count),
        .o_action     (w_action),
        .o_index      (w_index),
        .o_status     (w_status),
        .o_next_count (w_next_count)
    );

    // Without a word in the request register the cells must only hold.
    always_comb begin
        w_cell_action = r_req_valid ? w_action : '0;
    end

    pol_cells #(
        .CAPACITY     (CAPACITY)
    ) u_cells (
        .i_clk        (i_clk),
        .i_update     (w_exec),
        .i_action     (w_cell_action),
        .i_index      (w_index),
        .i_count      (r_count),
        .i_next_count (w_next_count),
        .i_value      (r_value),
        .o_read_value (w_read_value),
        .o_head_value (w_head_value),
        .o_tail_value (w_tail_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (o_in_ready) begin
                r_req_valid <= i_in_valid;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_count     <= w_next_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode   <= i_opcode;
            r_value    <= i_value;
            r_position <= i_position;
        end
        if (w_exec) begin
            r_status     <= w_status;
            r_new_count  <= w_next_count;
            r_read_value <= w_read_value;
            r_head_value <= w_head_value;
            r_tail_value <= w_tail_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_new_count  = COUNT_W'(r_new_count);
    assign o_read_value = r_read_value;
    assign o_head_value = r_head_value;
    assign o_tail_value = r_tail_value;

endmodule

/* hdl/pol_decode.sv */
`timescale 1ns / 1ps

module pol_decode import pol_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic [OP_W-1:0]                       i_opcode,
    input  logic [POS_W-1:0]                      i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_count,
    output t_action                               o_action,
    output logic [$clog2(CAPACITY)-1:0]           o_index,
    output t_status                               o_status,
    output logic [$clog2(CAPACITY+1)-1:0]         o_next_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned WW = (CW > POS_W ? CW : POS_W) + 1;

    logic [WW-1:0] w_pos;
    logic [WW-1:0] w_cnt;
    logic          w_empty;
    logic          w_full;
    logic          w_ins_pos_ok;
    logic          w_rem_pos_ok;
    logic [WW-1:0] w_pos_m1;
    logic [WW-1:0] w_cnt_m1;

    always_comb begin
        w_pos        = WW'(i_position);
        w_cnt        = WW'(i_count);
        w_empty      = (i_count == '0);
        w_full       = (w_cnt >= WW'(CAPACITY));
        w_ins_pos_ok = (w_pos != '0) && (w_pos <= w_cnt + WW'(1));
        w_rem_pos_ok = (w_pos != '0) && (w_pos <= w_cnt);
        w_pos_m1     = w_pos - WW'(1);
        w_cnt_m1     = w_cnt - WW'(1);

        o_action     = '0;
        o_index      = '0;
        o_status     = ST_OK;
        o_next_count = i_count;

        case (t_opcode'(i_opcode))
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (t_opcode'(i_opcode) == OP_INS_AT && !w_ins_pos_ok) begin
                    o_status = ST_BADPOS;
                end else if (w_full) begin
                    o_status = ST_FULL;
                end else begin
                    o_action.do_insert = 1'b1;
                    o_next_count       = i_count + CW'(1);
                    case (t_opcode'(i_opcode))
                        OP_INS_BACK: o_index = w_cnt[IW-1:0];
                        OP_INS_AT:   o_index = w_pos_m1[IW-1:0];
                        default:     o_index = '0;
                    endcase
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (t_opcode'(i_opcode) == OP_REM_AT && !w_rem_pos_ok) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_action.do_remove = 1'b1;
                    o_next_count       = i_count - CW'(1);
                    case (t_opcode'(i_opcode))
                        OP_REM_BACK: o_index = w_cnt_m1[IW-1:0];
                        OP_REM_AT:   o_index = w_pos_m1[IW-1:0];
                        default:     o_index = '0;
                    endcase
                end
            end
            OP_READ: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (!w_rem_pos_ok) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_action.do_read = 1'b1;
                    o_index          = w_pos_m1[IW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/pol_cells.sv */
`timescale 1ns / 1ps

module pol_cells import pol_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_update,
    input  t_action                               i_action,
    input  logic [$clog2(CAPACITY)-1:0]           i_index,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_count,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_next_count,
    input  logic [DATA_W-1:0]                     i_value,
    output logic [DATA_W-1:0]                     o_read_value,
    output logic [DATA_W-1:0]                     o_head_value,
    output logic [DATA_W-1:0]                     o_tail_value
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [DATA_W-1:0] r_cell [CAPACITY];
    logic [DATA_W-1:0] n_cell [CAPACITY];
    logic [CW-1:0]     w_last;

    // Every cell looks only at its neighbours: behind an insert point a
    // cell takes the one in front, at or behind a removal point the one behind.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (i_action.do_insert) begin
                if (CW'(i) == CW'(i_index)) begin
                    n_cell[i] = i_value;
                end else if (i > 0 && CW'(i) > CW'(i_index) && CW'(i) <= i_count) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_action.do_remove) begin
                if (i < CAPACITY - 1 && CW'(i) >= CW'(i_index)
                        && CW'(i + 1) < i_count) begin
                    n_cell[i] = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end

    always_comb begin
        w_last       = i_next_count - CW'(1);
        o_read_value = i_action.do_read ? r_cell[i_index] : '0;
        if (i_next_count == '0) begin
            o_head_value = '0;
            o_tail_value = '0;
        end else begin
            o_head_value = n_cell[0];
            o_tail_value = n_cell[w_last[$clog2(CAPACITY)-1:0]];
        end
    end

endmodule
